// File: hw/rtl/pwm_pkg.sv
// Shared types, constants and coefficient table of the prolate window multiplier.
package pwm_pkg;

    // Fixed-point layout of the polynomial.
    localparam int COEF_FRAC_BITS = 30;
    localparam int SRC_FRAC_BITS  = 40;
    localparam int COEF_SHIFT     = SRC_FRAC_BITS - COEF_FRAC_BITS;
    localparam int NUM_COEF       = 11;
    localparam int COEF_IDX_BITS  = 4;
    localparam int ACC_BITS       = 32;

    // Shared multiplier.
    localparam int MUL_BITS  = 32;
    localparam int PROD_BITS = 2 * MUL_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int LENGTH_BITS    = 17;
    localparam int GAIN_BITS      = 31;
    localparam int WINDOW_BITS    = 31;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_ONLY    = 3'd3;

    localparam logic [LENGTH_BITS-1:0] RESET_WINDOW_LENGTH  = 17'd1024;
    localparam logic [31:0]            RESET_INVERSE_LENGTH = 32'd4194304;
    localparam logic [GAIN_BITS-1:0]   RESET_WINDOW_GAIN    = 31'd47453133;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_POS_MUL,
        OP_ABS,
        OP_SQ_MUL,
        OP_U,
        OP_H_MUL,
        OP_H_ADD,
        OP_GAIN_MUL,
        OP_W_SAT,
        OP_S_MUL,
        OP_RESULT
    } pwm_op_t;

    typedef struct packed {
        pwm_op_t                  op;
        logic [COEF_IDX_BITS-1:0] coef_index;
    } pwm_cmd_t;

    typedef struct packed {
        logic window_only;
        logic out_busy;
    } pwm_status_t;

    // Polynomial coefficients, highest power first, held in Q.40 and
    // rounded half up to Q.COEF_FRAC_BITS.
    function automatic logic [ACC_BITS-1:0] coef_at(logic [COEF_IDX_BITS-1:0] k);
        logic [63:0] src;
        logic [63:0] res;
        case (k)
            4'd0:    src = 64'd59;
            4'd1:    src = 64'd2491;
            4'd2:    src = 64'd85844;
            4'd3:    src = 64'd2350031;
            4'd4:    src = 64'd49582309;
            4'd5:    src = 64'd775144232;
            4'd6:    src = 64'd8511615643;
            4'd7:    src = 64'd60781692674;
            4'd8:    src = 64'd250180173501;
            4'd9:    src = 64'd477560827929;
            4'd10:   src = 64'd251810723190;
            default: src = 64'd0;
        endcase
        res = (src + (64'd1 << (COEF_SHIFT - 1))) >> COEF_SHIFT;
        return res[ACC_BITS-1:0];
    endfunction

endpackage

// File: hw/rtl/prolate_window_multiply.sv
// Top level of the prolate-spheroidal window multiplier.
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ----------------------------------------
//  in       sink       in_valid / in_ready   sample
//  out      source     out_valid / out_ready weighted_sample, window_value, frame_end
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each item is worked through the sequencer's steps before the next one can be
// accepted, and its result is loaded into the output register at the end; in
// window-only mode the sample product step is skipped. The order is set by the
// single shared 32x32 multiplier, which does the position product, the
// square, ten Horner steps (each a multiply state and an add state), the gain
// and the sample product in turn.
// Reset is asynchronous and active low; it loads every configuration register
// with its default value and clears the frame position and the output valid flag.
// A result waiting in the output register does not block the next input
// item; only the hand-over of the following result waits for out_ready.
// The configuration port is always ready and must only be written while no
// item is in flight.
module prolate_window_multiply #(
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      sample,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      weighted_sample,
    output logic [pwm_pkg::WINDOW_BITS-1:0]    window_value,
    output logic                               frame_end,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pwm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    pwm_pkg::pwm_cmd_t    cmd;
    pwm_pkg::pwm_status_t status;

    // Register writes are taken as they arrive, so the port never stalls.
    assign cfg_ready = 1'b1;

    // The sequencer walks each item through the arithmetic steps.
    pwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the frame counter, the shared
    // multiplier with its working registers, and the output register.
    pwm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample          (sample),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .weighted_sample (weighted_sample),
        .window_value    (window_value),
        .frame_end       (frame_end)
    );

endmodule

// File: hw/rtl/pwm_ctrl.sv
// Sequencer that steps the shared-multiplier datapath through one item.
module pwm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pwm_pkg::pwm_status_t status,
    output pwm_pkg::pwm_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_ABS,
        ST_SQ,
        ST_U,
        ST_HMUL,
        ST_HADD,
        ST_GAIN,
        ST_WSAT,
        ST_SMUL,
        ST_DONE
    } state_t;

    localparam logic [pwm_pkg::COEF_IDX_BITS-1:0] LAST_COEF =
        pwm_pkg::COEF_IDX_BITS'(pwm_pkg::NUM_COEF - 1);

    localparam logic [pwm_pkg::COEF_IDX_BITS-1:0] COEF_IDX_BITS_ONE =
        pwm_pkg::COEF_IDX_BITS'(1);

    state_t                             state_reg;
    logic [pwm_pkg::COEF_IDX_BITS-1:0]  k_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.coef_index = k_reg;
        case (state_reg)
            ST_IDLE: cmd.op = in_valid ? pwm_pkg::OP_ACCEPT : pwm_pkg::OP_NONE;
            ST_POS:  cmd.op = pwm_pkg::OP_POS_MUL;
            ST_ABS:  cmd.op = pwm_pkg::OP_ABS;
            ST_SQ:   cmd.op = pwm_pkg::OP_SQ_MUL;
            ST_U:    cmd.op = pwm_pkg::OP_U;
            ST_HMUL: cmd.op = pwm_pkg::OP_H_MUL;
            ST_HADD: cmd.op = pwm_pkg::OP_H_ADD;
            ST_GAIN: cmd.op = pwm_pkg::OP_GAIN_MUL;
            ST_WSAT: cmd.op = pwm_pkg::OP_W_SAT;
            ST_SMUL: cmd.op = pwm_pkg::OP_S_MUL;
            ST_DONE: cmd.op = status.out_busy ? pwm_pkg::OP_NONE : pwm_pkg::OP_RESULT;
            default: cmd.op = pwm_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_POS;
                    end
                end
                ST_POS:  state_reg <= ST_ABS;
                ST_ABS:  state_reg <= ST_SQ;
                ST_SQ:   state_reg <= ST_U;
                ST_U:
                begin
                    k_reg     <= COEF_IDX_BITS_ONE;
                    state_reg <= ST_HMUL;
                end
                ST_HMUL: state_reg <= ST_HADD;
                ST_HADD:
                begin
                    if (k_reg == LAST_COEF)
                    begin
                        state_reg <= ST_GAIN;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_HMUL;
                    end
                end
                ST_GAIN: state_reg <= ST_WSAT;
                ST_WSAT: state_reg <= status.window_only ? ST_DONE : ST_SMUL;
                ST_SMUL: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The Horner index only ever walks the coefficients after the first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HMUL || state_reg == ST_HADD)
            |-> (k_reg >= COEF_IDX_BITS_ONE && k_reg <= LAST_COEF))
        else $error("Horner index out of range");

    // Once an item is taken no second item may enter until it is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && state_reg == ST_POS))
        else $error("input accepted while an item is in flight");

    // A finished item leaves the sequencer as soon as the output stage is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !status.out_busy) |=> (state_reg == ST_IDLE))
        else $error("result not handed to the output stage");

endmodule

// File: hw/rtl/pwm_datapath.sv
// Datapath: configuration registers, frame counter, shared multiplier and output stage.
module pwm_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_LENGTH  = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pwm_pkg::pwm_cmd_t                    cmd,
    output pwm_pkg::pwm_status_t                 status,
    input  logic                                 cfg_valid,
    input  logic [pwm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pwm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [SAMPLE_BITS-1:0]        weighted_sample,
    output logic [pwm_pkg::WINDOW_BITS-1:0]      window_value,
    output logic                                 frame_end
);

    localparam int LEN_CMP_BITS = 21;
    localparam int POS_BITS     = (MAX_LENGTH > 131072) ? 17 : $clog2(MAX_LENGTH);
    localparam logic [LEN_CMP_BITS-1:0] LEN_CAP = LEN_CMP_BITS'(MAX_LENGTH);
    localparam int WO_SHIFT = 32 - SAMPLE_BITS;
    localparam int WO_RND   = (WO_SHIFT == 0) ? 0 : (1 << (WO_SHIFT - 1));
    localparam logic [33:0] MAX_POS = 34'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [33:0] MAX_NEG = 34'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [pwm_pkg::WINDOW_BITS-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [63:0] TWO_Q32 = 64'h2_0000_0000;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

    // Configuration registers.
    logic [pwm_pkg::LENGTH_BITS-1:0] window_length_reg;
    logic [31:0]                     inverse_length_reg;
    logic [pwm_pkg::GAIN_BITS-1:0]   window_gain_reg;
    logic                            window_only_reg;

    // Frame and item registers.
    logic [POS_BITS-1:0]             frame_pos_reg;
    logic [POS_BITS-1:0]             work_pos_reg;
    logic [SAMPLE_BITS-1:0]          sample_reg;
    logic                            last_reg;

    // Arithmetic registers.
    logic [pwm_pkg::PROD_BITS-1:0]   prod_reg;
    logic [31:0]                     a_reg;
    logic                            a_sat_reg;
    logic [31:0]                     u_reg;
    logic [pwm_pkg::ACC_BITS-1:0]    acc_reg;
    logic [pwm_pkg::WINDOW_BITS-1:0] w30_reg;

    // Output stage.
    logic                            out_valid_reg;
    logic [SAMPLE_BITS-1:0]          ws_reg;
    logic [pwm_pkg::WINDOW_BITS-1:0] wv_reg;
    logic                            fe_reg;

    // Combinational values.
    logic [LEN_CMP_BITS-1:0]         len_eff;
    logic [LEN_CMP_BITS-1:0]         pos_plus1;
    logic                            last_next;
    logic [POS_BITS-1:0]             frame_pos_next;
    logic [POS_BITS:0]               pos_odd;
    logic [SAMPLE_BITS:0]            mag_wide;
    logic [pwm_pkg::MUL_BITS-1:0]    mul_a;
    logic [pwm_pkg::MUL_BITS-1:0]    mul_b;
    logic [pwm_pkg::PROD_BITS-1:0]   mul_product;
    logic [63:0]                     t_clamped;
    logic [63:0]                     a_full;
    logic [63:0]                     sum31;
    logic [63:0]                     sum29;
    logic [31:0]                     rnd32;
    logic [33:0]                     rnd30;
    logic [31:0]                     u_next;
    logic [pwm_pkg::ACC_BITS-1:0]    acc_next;
    logic [pwm_pkg::WINDOW_BITS-1:0] w30_next;
    logic [33:0]                     q_clamped;
    logic [33:0]                     q_negated;
    logic [34:0]                     wo_wide;
    logic [SAMPLE_BITS-1:0]          ws_next;

    assign status.window_only = window_only_reg;
    assign status.out_busy    = out_valid_reg && !out_ready;

    // Frame position bookkeeping at item acceptance.
    always_comb
    begin
        len_eff = ({4'b0, window_length_reg} > LEN_CAP) ? LEN_CAP : {4'b0, window_length_reg};
        pos_plus1 = LEN_CMP_BITS'(frame_pos_reg) + 1'b1;
        last_next = (len_eff <= LEN_CMP_BITS'(1)) || (pos_plus1 >= len_eff);
        frame_pos_next = last_next ? '0 : pos_plus1[POS_BITS-1:0];
    end

    // Operand selection for the shared 32x32 multiplier.
    always_comb
    begin
        pos_odd  = {work_pos_reg, 1'b1};
        mag_wide = sample_reg[SAMPLE_BITS-1]
                 ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, sample_reg})
                 : {1'b0, sample_reg};
        case (cmd.op)
            pwm_pkg::OP_POS_MUL:
            begin
                mul_a = pwm_pkg::MUL_BITS'(pos_odd);
                mul_b = inverse_length_reg;
            end
            pwm_pkg::OP_SQ_MUL:
            begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
            pwm_pkg::OP_H_MUL:
            begin
                mul_a = acc_reg;
                mul_b = u_reg;
            end
            pwm_pkg::OP_GAIN_MUL:
            begin
                mul_a = acc_reg;
                mul_b = {1'b0, window_gain_reg};
            end
            pwm_pkg::OP_S_MUL:
            begin
                mul_a = pwm_pkg::MUL_BITS'(mag_wide);
                mul_b = {1'b0, w30_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_product = mul_a * mul_b;
    end

    // Post-multiply arithmetic, working from the product register and the working registers.
    always_comb
    begin
        t_clamped = (prod_reg > TWO_Q32) ? TWO_Q32 : prod_reg;
        a_full    = (t_clamped >= ONE_Q32) ? (t_clamped - ONE_Q32) : (ONE_Q32 - t_clamped);

        sum31 = prod_reg + 64'h8000_0000;
        rnd32 = sum31[63:32];
        sum29 = prod_reg + 64'h2000_0000;
        rnd30 = sum29[63:30];

        // u = 1 - a^2, zero when a saturates, with the square rounding to zero giving all ones.
        if (a_sat_reg)
        begin
            u_next = '0;
        end
        else if (rnd32 == 32'd0)
        begin
            u_next = '1;
        end
        else
        begin
            u_next = 32'(33'h1_0000_0000 - {1'b0, rnd32});
        end

        acc_next = rnd32 + pwm_pkg::coef_at(cmd.coef_index);

        w30_next = (rnd30 > {3'b0, ONE_Q30}) ? ONE_Q30 : rnd30[pwm_pkg::WINDOW_BITS-1:0];

        // Sample product, saturated to the signed sample range; in window-only mode the rounded window instead.
        if (sample_reg[SAMPLE_BITS-1])
        begin
            q_clamped = (rnd30 > MAX_NEG) ? MAX_NEG : rnd30;
        end
        else
        begin
            q_clamped = (rnd30 > MAX_POS) ? MAX_POS : rnd30;
        end
        q_negated = 34'd0 - q_clamped;

        wo_wide = ({4'b0, w30_reg} + 35'(WO_RND)) >> WO_SHIFT;

        if (window_only_reg)
        begin
            ws_next = wo_wide[SAMPLE_BITS-1:0];
        end
        else if (sample_reg[SAMPLE_BITS-1])
        begin
            ws_next = q_negated[SAMPLE_BITS-1:0];
        end
        else
        begin
            ws_next = q_clamped[SAMPLE_BITS-1:0];
        end
    end

    // Control state: configuration, frame position, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg  <= pwm_pkg::RESET_WINDOW_LENGTH;
            inverse_length_reg <= pwm_pkg::RESET_INVERSE_LENGTH;
            window_gain_reg    <= pwm_pkg::RESET_WINDOW_GAIN;
            window_only_reg    <= 1'b0;
            frame_pos_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    pwm_pkg::REG_WINDOW_LENGTH:
                        window_length_reg <= cfg_data[pwm_pkg::LENGTH_BITS-1:0];
                    pwm_pkg::REG_INVERSE_LENGTH:
                        inverse_length_reg <= cfg_data;
                    pwm_pkg::REG_WINDOW_GAIN:
                        window_gain_reg <= cfg_data[pwm_pkg::GAIN_BITS-1:0];
                    pwm_pkg::REG_WINDOW_ONLY:
                        window_only_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.op == pwm_pkg::OP_ACCEPT)
            begin
                frame_pos_reg <= frame_pos_next;
            end
            if (cmd.op == pwm_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pwm_pkg::OP_ACCEPT:
            begin
                sample_reg   <= sample;
                work_pos_reg <= frame_pos_reg;
                last_reg     <= last_next;
            end
            pwm_pkg::OP_POS_MUL,
            pwm_pkg::OP_SQ_MUL,
            pwm_pkg::OP_H_MUL,
            pwm_pkg::OP_GAIN_MUL,
            pwm_pkg::OP_S_MUL:
            begin
                prod_reg <= mul_product;
            end
            pwm_pkg::OP_ABS:
            begin
                a_reg     <= a_full[31:0];
                a_sat_reg <= (a_full[63:32] != 32'd0);
            end
            pwm_pkg::OP_U:
            begin
                u_reg   <= u_next;
                acc_reg <= pwm_pkg::coef_at('0);
            end
            pwm_pkg::OP_H_ADD:
            begin
                acc_reg <= acc_next;
            end
            pwm_pkg::OP_W_SAT:
            begin
                w30_reg <= w30_next;
            end
            pwm_pkg::OP_RESULT:
            begin
                ws_reg <= ws_next;
                wv_reg <= w30_reg;
                fe_reg <= last_reg;
            end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign weighted_sample = ws_reg;
    assign window_value    = wv_reg;
    assign frame_end       = fe_reg;

    // The window value never leaves the saturation bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (wv_reg <= ONE_Q30))
        else $error("window value above 1.0");

    // The frame counter stays below the length cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        LEN_CMP_BITS'(frame_pos_reg) < LEN_CAP)
        else $error("frame position beyond the maximum length");

    // A result is only loaded into a free or draining output stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pwm_pkg::OP_RESULT) |-> (!out_valid_reg || out_ready))
        else $error("output stage overwritten");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the prolate window multiplier: random and directed samples.
`timescale 1ns / 100ps

module testbench;

    // Sample width and frame limit of the block as instantiated here.
    localparam int SAMPLE_W  = 24;
    localparam int MAX_FRAME = 65536;

    localparam int HALF_PERIOD     = 5;
    localparam int IDLE_PERCENT    = 22;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 236;
    localparam int STEADY_PHASE    = 3;
    localparam int NUM_TERMS       = 11;

    // An index that maps to no register; writes to it must change nothing.
    localparam logic [pwm_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd5;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = 24'h800000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO = 24'h000000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG1 = 24'hFFFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE  = 24'h000001;

    // Fixed-point anchors, all held at the predictor's working width.
    localparam logic [127:0] ONE_Q32  = 128'h1_0000_0000;
    localparam logic [127:0] TWO_Q32  = 128'h2_0000_0000;
    localparam logic [127:0] HALF_Q32 = 128'h8000_0000;
    localparam logic [127:0] U_MAX    = 128'hFFFF_FFFF;
    localparam logic [127:0] ONE_Q30  = 128'h4000_0000;
    localparam logic [127:0] HALF_Q30 = 128'h2000_0000;
    localparam logic [127:0] POS_LIMIT = 128'h7F_FFFF;
    localparam logic [127:0] NEG_LIMIT = 128'h80_0000;
    localparam int           WONLY_SHIFT = 32 - SAMPLE_W;

    // Polynomial in u, highest power first, in Q.40.
    localparam logic [63:0] POLY_Q40 [0:NUM_TERMS-1] = '{
        64'd59, 64'd2491, 64'd85844, 64'd2350031, 64'd49582309, 64'd775144232,
        64'd8511615643, 64'd60781692674, 64'd250180173501, 64'd477560827929,
        64'd251810723190
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0]             weighted;
        logic [pwm_pkg::WINDOW_BITS-1:0] window;
        logic                            frame_end;
    } weighting_t;

    // Clock, reset and every block input start at known values.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic [SAMPLE_W-1:0]                sample    = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [SAMPLE_W-1:0]                weighted_sample;
    logic [pwm_pkg::WINDOW_BITS-1:0]    window_value;
    logic                               frame_end;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [pwm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [pwm_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Our copy of the register file and the frame counter, updated only when
    // the block itself takes a write or an item.
    logic [pwm_pkg::LENGTH_BITS-1:0] len_shadow   = pwm_pkg::RESET_WINDOW_LENGTH;
    logic [31:0]                     recip_shadow = pwm_pkg::RESET_INVERSE_LENGTH;
    logic [pwm_pkg::GAIN_BITS-1:0]   gain_shadow  = pwm_pkg::RESET_WINDOW_GAIN;
    logic                            wonly_shadow = 1'b0;
    logic [127:0]                    position     = '0;

    logic [SAMPLE_W-1:0] sample_backlog [$];
    weighting_t          awaited_weights [$];
    weighting_t          want;

    int unsigned samples_queued   = 0;
    int unsigned samples_taken    = 0;
    int unsigned reg_writes_taken = 0;
    int unsigned quiet_cycles     = 0;
    int unsigned mismatch_count   = 0;
    logic        in_taken         = 1'b0;
    logic        steady_flow      = 1'b0;

    prolate_window_multiply dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .weighted_sample (weighted_sample),
        .window_value    (window_value),
        .frame_end       (frame_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Works out the weighted sample for the current frame position and then
    // advances the position. All arithmetic runs at 128 bits, so every
    // product is exact before its rounding shift.
    function automatic weighting_t weigh_sample(input logic [SAMPLE_W-1:0] raw);
        weighting_t   res;
        logic [127:0] span;
        logic [127:0] t;
        logic [127:0] a_mag;
        logic [127:0] u;
        logic [127:0] acc;
        logic [127:0] coef;
        logic [127:0] w;
        logic [127:0] mag;
        logic [127:0] q;
        logic         neg;
        logic         last;
        int           k;
        span = (len_shadow > pwm_pkg::LENGTH_BITS'(MAX_FRAME))
             ? 128'(MAX_FRAME) : 128'(len_shadow);

        // Position inside the frame mapped to xt = (2i+1)/N - 1; anything
        // beyond t = 2.0 is treated as the edge of the window.
        t = (128'd2 * position + 128'd1) * 128'(recip_shadow);
        if (t > TWO_Q32)
            t = TWO_Q32;
        a_mag = (t >= ONE_Q32) ? t - ONE_Q32 : ONE_Q32 - t;
        if (a_mag >= ONE_Q32)
            u = '0;
        else
        begin
            u = ONE_Q32 - ((a_mag * a_mag + HALF_Q32) >> 32);
            if (u > U_MAX)
                u = U_MAX;
        end

        // Horner's rule; starting from zero makes the first step load the
        // leading coefficient. Coefficients are rounded half up from Q.40.
        acc = '0;
        for (k = 0; k < NUM_TERMS; k++)
        begin
            coef = (128'(POLY_Q40[k]) + (128'd1 << (pwm_pkg::COEF_SHIFT - 1)))
                 >> pwm_pkg::COEF_SHIFT;
            acc  = ((acc * u + HALF_Q32) >> 32) + coef;
        end

        // Gain, then clamp the window at 1.0.
        w = (acc * 128'(gain_shadow) + HALF_Q30) >> 30;
        if (w > ONE_Q30)
            w = ONE_Q30;

        if (wonly_shadow)
            q = (w + (128'd1 << (WONLY_SHIFT - 1))) >> WONLY_SHIFT;
        else
        begin
            // Sign and magnitude, so the product rounds half away from zero.
            neg = raw[SAMPLE_W-1];
            mag = neg ? (128'd1 << SAMPLE_W) - 128'(raw) : 128'(raw);
            q   = (mag * w + HALF_Q30) >> 30;
            if (neg)
            begin
                if (q > NEG_LIMIT)
                    q = NEG_LIMIT;
                q = 128'd0 - q;
            end
            else if (q > POS_LIMIT)
                q = POS_LIMIT;
        end

        // A length of 0 or 1, the last position, or a position already past a
        // shortened length, ends the frame on this sample.
        last     = (span <= 128'd1) || (position + 128'd1 >= span);
        position = last ? 128'd0 : position + 128'd1;

        res.weighted  = q[SAMPLE_W-1:0];
        res.window    = w[pwm_pkg::WINDOW_BITS-1:0];
        res.frame_end = last;
        return res;
    endfunction

    // Driver: both the sample channel and the result back-pressure change on
    // the falling edge. A presented item is held until the rising edge that
    // takes it; each side idles with a probability of about one in five unless
    // the steady stretch is on.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
            if (!in_valid || in_taken)
            begin
                if (sample_backlog.size() != 0 &&
                    (steady_flow || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    in_valid <= 1'b1;
                    sample   <= sample_backlog.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: every handshake is observed at the rising edge. Results are
    // checked first, then register writes and new items update our copy of
    // the block, in the same order the hardware sees them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken     <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;

            if (out_valid && out_ready)
            begin
                if (awaited_weights.size() == 0)
                begin
                    $display("%0t: result with no item outstanding: weighted_sample %0d",
                             $time, $signed(weighted_sample));
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_weights.pop_front();
                    if (weighted_sample !== want.weighted)
                    begin
                        $display("%0t: weighted_sample expected %0d actual %0d", $time,
                                 $signed(want.weighted), $signed(weighted_sample));
                        mismatch_count++;
                    end
                    if (window_value !== want.window)
                    begin
                        $display("%0t: window_value expected %0d actual %0d", $time,
                                 want.window, window_value);
                        mismatch_count++;
                    end
                    if (frame_end !== want.frame_end)
                    begin
                        $display("%0t: frame_end expected %0b actual %0b", $time,
                                 want.frame_end, frame_end);
                        mismatch_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pwm_pkg::REG_WINDOW_LENGTH:
                        len_shadow = cfg_data[pwm_pkg::LENGTH_BITS-1:0];
                    pwm_pkg::REG_INVERSE_LENGTH:
                        recip_shadow = cfg_data;
                    pwm_pkg::REG_WINDOW_GAIN:
                        gain_shadow = cfg_data[pwm_pkg::GAIN_BITS-1:0];
                    pwm_pkg::REG_WINDOW_ONLY:
                        wonly_shadow = cfg_data[0];
                    default:            ;
                endcase
                reg_writes_taken++;
            end

            if (in_valid && in_ready)
            begin
                awaited_weights.push_back(weigh_sample(sample));
                samples_taken++;
            end

            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a long run of cycles with no handshake on any channel means
    // the block has hung.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        sample_backlog.push_back(s);
        samples_queued++;
    endtask

    // One register write, held until the monitor has seen it taken.
    task automatic write_register(input logic [pwm_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [pwm_pkg::CFG_DATA_BITS-1:0] data);
        int unsigned target;
        target = reg_writes_taken + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (reg_writes_taken != target);
        cfg_valid <= 1'b0;
    endtask

    // Every queued item has been taken and every result has come back; the
    // block holds nothing in flight, so registers may be written.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (samples_taken != samples_queued || awaited_weights.size() != 0);
    endtask

    // Picks a frame setting for one random phase. Most are consistent
    // (reciprocal and gain derived from the length, short frames so the
    // window is swept edge to edge many times); some get arbitrary
    // reciprocal or gain values. Bits above each register's width carry junk.
    task automatic pick_setting();
        int unsigned span;
        int unsigned eff;
        int unsigned pick;
        logic [63:0] recip;
        logic [31:0] roll;
        logic [31:0] gain;
        logic        wonly;
        pick = $urandom_range(99);
        if (pick < 55)
            span = $urandom_range(2, 48);
        else if (pick < 65)
            span = 2;
        else if (pick < 75)
            span = MAX_FRAME;
        else if (pick < 88)
            span = $urandom_range(49, MAX_FRAME);
        else if (pick < 94)
            span = $urandom_range(MAX_FRAME + 1, (1 << pwm_pkg::LENGTH_BITS) - 1);
        else
            span = $urandom_range(0, 1);
        eff   = (span > MAX_FRAME) ? MAX_FRAME : ((span < 2) ? 2 : span);
        recip = ((64'd1 << 32) + 64'(eff / 2)) / 64'(eff);
        gain  = 32'($rtoi($sqrt(2.0 / eff) * 1073741824.0));
        if ($urandom_range(4) == 0)
            recip = {32'd0, $urandom};
        if ($urandom_range(4) == 0)
            gain = $urandom;
        wonly = ($urandom_range(3) == 0);

        roll = $urandom;
        write_register(pwm_pkg::REG_WINDOW_LENGTH,
                       {roll[31:pwm_pkg::LENGTH_BITS], span[pwm_pkg::LENGTH_BITS-1:0]});
        write_register(pwm_pkg::REG_INVERSE_LENGTH, recip[31:0]);
        roll = $urandom;
        write_register(pwm_pkg::REG_WINDOW_GAIN, {roll[31], gain[pwm_pkg::GAIN_BITS-1:0]});
        roll = $urandom;
        write_register(pwm_pkg::REG_WINDOW_ONLY, {roll[31:1], wonly});
    endtask

    initial
    begin
        int          phase;
        logic [31:0] roll;

        // Reset is held low from the start and released on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default setting: sample extremes at the start of a 1024 frame.
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_ZERO);
        queue_sample(SAMPLE_NEG1);
        queue_sample(SAMPLE_ONE);
        queue_sample(24'h555555);
        wait_until_drained();

        // Lengths of zero and one: every sample closes a frame. The smallest
        // reciprocal rides along.
        write_register(pwm_pkg::REG_WINDOW_LENGTH, 32'd0);
        write_register(pwm_pkg::REG_INVERSE_LENGTH, 32'd32768);
        queue_sample(24'hAAAAAA);
        queue_sample(SAMPLE_MAX);
        wait_until_drained();
        write_register(pwm_pkg::REG_WINDOW_LENGTH, 32'd1);
        queue_sample(SAMPLE_MIN);
        queue_sample(24'h123456);
        wait_until_drained();

        // Walk into a frame of eight, then shrink the frame below the
        // current position: the next sample must close the frame and wrap,
        // and the write itself must leave the position alone.
        write_register(pwm_pkg::REG_WINDOW_LENGTH, 32'd8);
        write_register(pwm_pkg::REG_INVERSE_LENGTH, 32'h2000_0000);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(24'h400000);
        wait_until_drained();
        write_register(pwm_pkg::REG_WINDOW_LENGTH, 32'd2);
        queue_sample(24'hC00000);
        wait_until_drained();

        // Length beyond the maximum, largest reciprocal (t runs past 2.0 from
        // the second position on) and largest gain, in window-only mode:
        // the window saturates at 1.0 on the first position.
        write_register(pwm_pkg::REG_WINDOW_LENGTH, 32'h0001_FFFF);
        write_register(pwm_pkg::REG_INVERSE_LENGTH, 32'hFFFF_FFFF);
        write_register(pwm_pkg::REG_WINDOW_GAIN, 32'h7FFF_FFFF);
        write_register(pwm_pkg::REG_WINDOW_ONLY, 32'd1);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_ZERO);
        wait_until_drained();

        // Same setting with the product: full-scale samples of both signs, further
        // into the frame where the window is below 1.0.
        write_register(pwm_pkg::REG_WINDOW_ONLY, 32'd0);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        wait_until_drained();

        // Zero gain, plus a write to an unmapped index that must be ignored.
        write_register(pwm_pkg::REG_WINDOW_GAIN, 32'd0);
        write_register(REG_UNMAPPED, $urandom);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_NEG1);
        wait_until_drained();

        // Random phases, each under a fresh setting. One phase runs with no
        // idling on either side.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_setting();
            steady_flow = (phase == STEADY_PHASE);
            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom;
                case ($urandom_range(15))
                    0:       queue_sample(SAMPLE_MAX);
                    1:       queue_sample(SAMPLE_MIN);
                    2:       queue_sample(SAMPLE_ZERO);
                    3:       queue_sample(SAMPLE_NEG1);
                    default: queue_sample(roll[SAMPLE_W-1:0]);
                endcase
            end
            wait_until_drained();
            steady_flow = 1'b0;
        end

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
